### rtl/csmf_pkg.sv
// Package for the clamped sliding median filter core.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csmf_pkg;

    // Widths of the payload fields and of the configuration port.
    localparam int SAMPLE_W    = 16;
    localparam int MEDIAN_W    = 17;
    localparam int SIZE_FLD_W  = 7;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int BIT_IDX_W   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd2;

    // Window size after reset.
    localparam int WINDOW_SIZE_RESET = 40;

    // Flipping the sign bit maps signed order onto unsigned order.
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_STEP = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

### rtl/clamped_sliding_median_filter_core.sv
// Top level of the clamped sliding median filter: clamp, ring window, median search.
// Depends on csmf_pkg and csmf_ram.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Signals                                 Transfer when
//  input     in         in_valid, in_stall, sample              in_valid && !in_stall
//  output    out        out_valid, out_stall, clamped,
//                       median_ready, median                    out_valid && !out_stall
//  config    in         cfg_we, cfg_index, cfg_data             cfg_we
//
// Until the window has filled, an item goes from ST_IDLE straight to ST_DONE. Afterwards
// the median is found by a bitwise search that sweeps the window RAM once per result
// bit: 16 passes for each of the two middle ranks. A pass in ST_SCAN issues window_size
// reads and waits for the last read data; ST_STEP then settles the bit. The single RAM
// read port and one compare-and-count unit set the pace of the search. Reset sets the
// window size to 40 (or WINDOW_MAX if smaller), both limits to 0 and clears the fill
// state; the window RAM itself is not cleared. One item is worked on at a time; the
// finished result sits in an output register, and a new sample is taken while it waits
// on out_stall.

module clamped_sliding_median_filter_core #(
    parameter int WINDOW_MAX = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [csmf_pkg::SAMPLE_W-1:0]  sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       clamped,
    output logic                                       median_ready,
    output logic signed [csmf_pkg::MEDIAN_W-1:0]       median,
    input  wire logic                                  cfg_we,
    input  wire logic [csmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [csmf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int NW = $clog2(WINDOW_MAX + 1);
    localparam int SW = (NW > csmf_pkg::SIZE_FLD_W) ? NW : csmf_pkg::SIZE_FLD_W;
    localparam int RESET_SIZE = (csmf_pkg::WINDOW_SIZE_RESET > WINDOW_MAX) ?
                                WINDOW_MAX : csmf_pkg::WINDOW_SIZE_RESET;
    localparam int DW = csmf_pkg::SAMPLE_W;

    csmf_pkg::state_t state_reg, state_next;

    logic [NW-1:0]         size_reg, size_next;
    logic signed [DW-1:0]  lower_reg, lower_next;
    logic signed [DW-1:0]  upper_reg, upper_next;
    logic [AW-1:0]         slot_reg, slot_next;
    logic                  full_reg, full_next;

    logic [NW-1:0]         idx_reg, idx_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [DW-1:0]         prefix_reg, prefix_next;
    logic [csmf_pkg::BIT_IDX_W-1:0] bit_reg, bit_next;
    logic                  sel_hi_reg, sel_hi_next;
    logic [DW-1:0]         lo_reg, lo_next;
    logic                  hit_reg, hit_next;
    logic signed [csmf_pkg::MEDIAN_W-1:0] med_reg, med_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  clamped_reg, clamped_next;
    logic                  ready_reg, ready_next;
    logic signed [csmf_pkg::MEDIAN_W-1:0] median_reg, median_next;

    logic                  in_xfer;
    logic                  out_free;
    logic signed [DW-1:0]  s_low;
    logic signed [DW-1:0]  s_clamped;
    logic                  hit_low;
    logic                  hit_high;
    logic [AW-1:0]         slot_eff;
    logic [SW-1:0]         size_raw;
    logic [NW-1:0]         size_clamped;

    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_rdata;

    logic [DW-1:0]         low_mask;
    logic [DW-1:0]         thresh;
    logic [NW-1:0]         rank;
    logic                  below;
    logic [DW-1:0]         found;
    logic signed [csmf_pkg::MEDIAN_W-1:0] lo_ext;
    logic signed [csmf_pkg::MEDIAN_W-1:0] hi_ext;

    assign in_stall     = (state_reg != csmf_pkg::ST_IDLE);
    assign in_xfer      = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign clamped      = clamped_reg;
    assign median_ready = ready_reg;
    assign median       = median_reg;

    // Clamp: floor first, then ceiling, each only when its limit is positive.
    always_comb
    begin
        hit_low  = (lower_reg > 16'sd0) && (sample <= lower_reg);
        s_low    = hit_low ? lower_reg : sample;
        hit_high = (upper_reg > 16'sd0) && (s_low >= upper_reg);
        s_clamped = hit_high ? upper_reg : s_low;
    end

    // Slot that the new sample goes to.
    assign slot_eff = (NW'(slot_reg) >= size_reg) ? '0 : slot_reg;

    // Window size write: zero reads as one, too large reads as the maximum.
    always_comb
    begin
        size_raw = SW'(cfg_data[csmf_pkg::SIZE_FLD_W-1:0]);
        if (size_raw == '0)
        begin
            size_clamped = NW'(1);
        end
        else if (size_raw > SW'(WINDOW_MAX))
        begin
            size_clamped = NW'(WINDOW_MAX);
        end
        else
        begin
            size_clamped = NW'(size_raw);
        end
    end

    function automatic logic signed [csmf_pkg::MEDIAN_W-1:0] MEDIAN_EXT(
        input logic [DW-1:0] v
    );
        MEDIAN_EXT = {v[DW-1], v};
    endfunction

    // Search datapath: count window entries at or below the trial threshold.
    always_comb
    begin
        low_mask = (DW'(1) << bit_reg) - DW'(1);
        thresh   = prefix_reg | low_mask;
        rank     = sel_hi_reg ? (size_reg >> 1) : ((size_reg - NW'(1)) >> 1);
        below    = (ram_rdata ^ csmf_pkg::SIGN_FLIP) <= thresh;
        found    = (cnt_reg > rank) ? prefix_reg : (prefix_reg | (DW'(1) << bit_reg));
        lo_ext   = MEDIAN_EXT(lo_reg ^ csmf_pkg::SIGN_FLIP);
        hi_ext   = MEDIAN_EXT(found ^ csmf_pkg::SIGN_FLIP);
    end

    assign ram_we    = in_xfer;
    assign ram_re    = (state_reg == csmf_pkg::ST_SCAN) && (idx_reg < size_reg);
    assign ram_raddr = idx_reg[AW-1:0];

    // Sequencer and register updates.
    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = 1'b0;
        prefix_next    = prefix_reg;
        bit_next       = bit_reg;
        sel_hi_next    = sel_hi_reg;
        lo_next        = lo_reg;
        hit_next       = hit_reg;
        med_next       = med_reg;
        out_valid_next = out_valid_reg && out_stall;
        clamped_next   = clamped_reg;
        ready_next     = ready_reg;
        median_next    = median_reg;

        // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
        if (cfg_we)
        begin
            unique case (cfg_index)
                csmf_pkg::REG_WINDOW_SIZE:
                begin
                    size_next = size_clamped;
                    slot_next = '0;
                    full_next = 1'b0;
                end
                csmf_pkg::REG_LOWER_LIMIT: lower_next = cfg_data;
                csmf_pkg::REG_UPPER_LIMIT: upper_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            csmf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    hit_next = hit_low || hit_high;
                    med_next = '0;
                    if (NW'(slot_eff) == size_reg - NW'(1))
                    begin
                        slot_next   = '0;
                        full_next   = 1'b1;
                        idx_next    = '0;
                        cnt_next    = '0;
                        prefix_next = '0;
                        bit_next    = csmf_pkg::BIT_IDX_W'(DW - 1);
                        sel_hi_next = 1'b0;
                        state_next  = csmf_pkg::ST_SCAN;
                    end
                    else
                    begin
                        slot_next = slot_eff + AW'(1);
                        if (full_reg)
                        begin
                            idx_next    = '0;
                            cnt_next    = '0;
                            prefix_next = '0;
                            bit_next    = csmf_pkg::BIT_IDX_W'(DW - 1);
                            sel_hi_next = 1'b0;
                            state_next  = csmf_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = csmf_pkg::ST_DONE;
                        end
                    end
                end
            end

            csmf_pkg::ST_SCAN:
            begin
                // Issue one read per cycle; count the entry that returns.
                if (idx_reg < size_reg)
                begin
                    idx_next    = idx_reg + NW'(1);
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg && below)
                begin
                    cnt_next = cnt_reg + NW'(1);
                end
                if ((idx_reg == size_reg) && !rd_vld_reg)
                begin
                    state_next = csmf_pkg::ST_STEP;
                end
            end

            csmf_pkg::ST_STEP:
            begin
                // Settle one bit of the rank's value, then start the next pass or, once both ranks are done, finish.
                idx_next = '0;
                cnt_next = '0;
                if (bit_reg == '0)
                begin
                    if (sel_hi_reg)
                    begin
                        med_next   = lo_ext + hi_ext;
                        state_next = csmf_pkg::ST_DONE;
                    end
                    else
                    begin
                        lo_next     = found;
                        sel_hi_next = 1'b1;
                        prefix_next = '0;
                        bit_next    = csmf_pkg::BIT_IDX_W'(DW - 1);
                        state_next  = csmf_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    prefix_next = found;
                    bit_next    = bit_reg - csmf_pkg::BIT_IDX_W'(1);
                    state_next  = csmf_pkg::ST_SCAN;
                end
            end

            csmf_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    clamped_next   = hit_reg;
                    ready_next     = full_reg;
                    median_next    = med_reg;
                    state_next     = csmf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = csmf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csmf_pkg::ST_IDLE;
            size_reg      <= NW'(RESET_SIZE);
            lower_reg     <= '0;
            upper_reg     <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            bit_reg       <= '0;
            sel_hi_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            bit_reg       <= bit_next;
            sel_hi_reg    <= sel_hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prefix_reg  <= prefix_next;
        lo_reg      <= lo_next;
        hit_reg     <= hit_next;
        med_reg     <= med_next;
        clamped_reg <= clamped_next;
        ready_reg   <= ready_next;
        median_reg  <= median_next;
    end

    // Ring window storage.
    csmf_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_eff),
        .wdata (s_clamped),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### rtl/csmf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire
